@@ src/ppqb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppqb_pkg
// Shared types and constants for the priority process queue bank.
// ----------------------------------------------------------------------------
package ppqb_pkg;

    localparam int ENTRIES   = 32;
    localparam int QUEUES    = 8;
    localparam int PRIO_BITS = 8;
    localparam int EW        = $clog2(ENTRIES);
    localparam int QW        = $clog2(QUEUES);
    localparam int LW        = EW + 1;
    localparam int TW        = QW + 1;
    localparam int SW        = $clog2(ENTRIES + 1);

    localparam logic [LW-1:0] LINK_NONE = LW'(ENTRIES);
    localparam logic [TW-1:0] TAG_NONE  = TW'(QUEUES);

    typedef enum logic [2:0] {
        F_INSERT   = 3'd0,
        F_REM_HEAD = 3'd1,
        F_PEEK     = 3'd2,
        F_REM_ENT  = 3'd3,
        F_EMPTY_T  = 3'd4,
        F_MAKE_EMP = 3'd5
    } t_func;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_DUPL  = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic latch;      // capture request
        logic decode;     // decode cycle: walk setup, failure status
        logic walk_ins;   // one insert walk step
        logic ins_wb;     // insert write-back
        logic unlink;     // unlink target entry
        logic walk_clr;   // one make-empty step
        logic clr_done;   // clear head/tail
        logic respond;    // drive result word
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic [2:0] func;
        logic       q_ok;
        logic       e_ok;
        logic       e_tagged;
        logic       e_in_q;
        logic       head_none;
        logic       ins_stop;
        logic       clr_stop;
    } t_sts;

endpackage

@@ src/ppqb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppqb_ctrl
// Sequencer for queue operations: decode, walk, write-back or clear, respond.
// ----------------------------------------------------------------------------
module ppqb_ctrl
    import ppqb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEC  = 6'b000010,
        S_INS  = 6'b000100,
        S_INSW = 6'b001000,
        S_CLR  = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.decode = 1'b1;
                n_state      = S_RESP;
                if (i_sts.q_ok) begin
                    case (i_sts.func)
                        F_INSERT: begin
                            if (i_sts.e_ok && !i_sts.e_tagged) n_state = S_INS;
                        end
                        F_REM_HEAD: begin
                            if (!i_sts.head_none) o_cmd.unlink = 1'b1;
                        end
                        F_REM_ENT: begin
                            if (i_sts.e_ok && i_sts.e_in_q) o_cmd.unlink = 1'b1;
                        end
                        F_MAKE_EMP: n_state = S_CLR;
                        default: ;
                    endcase
                end
            end
            S_INS: begin
                if (i_sts.ins_stop) n_state = S_INSW;
                else o_cmd.walk_ins = 1'b1;
            end
            S_INSW: begin
                o_cmd.ins_wb = 1'b1;
                n_state      = S_RESP;
            end
            S_CLR: begin
                if (i_sts.clr_stop) begin
                    o_cmd.clr_done = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.walk_clr = 1'b1;
                end
            end
            S_RESP: begin
                o_cmd.respond = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign busy = (r_state != S_IDLE);

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_resp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.respond |=> !busy) else $error("no idle after respond");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_DEC)) else $error("start lost");

endmodule

@@ src/ppqb_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppqb_dp
// Link tables, queue pointers and walk registers of the queue bank.
// ----------------------------------------------------------------------------
module ppqb_dp
    import ppqb_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cmd           i_cmd,
    output t_sts           o_sts,
    input  logic [2:0]     i_func,
    input  logic [2:0]     i_queue_id,
    input  logic [4:0]     i_entry,
    input  logic [7:0]     i_priority_req,
    output logic           o_valid,
    output logic [1:0]     o_status,
    output logic [4:0]     o_out_entry,
    output logic           o_is_empty
);

    logic [LW-1:0]        r_head [QUEUES];
    logic [LW-1:0]        r_tail [QUEUES];
    logic [LW-1:0]        r_next [ENTRIES];
    logic [LW-1:0]        r_prev [ENTRIES];
    logic [PRIO_BITS-1:0] r_prio [ENTRIES];
    logic [TW-1:0]        r_tag  [ENTRIES];

    logic [2:0]           r_func;
    logic [2:0]           r_qid;
    logic [4:0]           r_ent;
    logic [PRIO_BITS-1:0] r_pri;
    logic [LW-1:0]        r_pos;
    logic [SW-1:0]        r_steps;
    logic [1:0]           r_status;
    logic [4:0]           r_oe;

    logic [QW-1:0]  q;
    logic [EW-1:0]  e;
    logic           q_ok, e_ok, pos_ok;
    logic [EW-1:0]  p;
    logic [LW-1:0]  hd;
    logic [LW-1:0]  tgt;
    logic [EW-1:0]  t;
    logic [LW-1:0]  nx, pv;

    assign q      = r_qid[QW-1:0];
    assign e      = r_ent[EW-1:0];
    assign q_ok   = (32'(r_qid) < QUEUES);
    assign e_ok   = (32'(r_ent) < ENTRIES);
    assign pos_ok = (r_pos < LINK_NONE);
    assign p      = r_pos[EW-1:0];
    assign hd     = r_head[q];
    assign tgt    = (r_func == F_REM_HEAD) ? hd : LW'(r_ent);
    assign t      = tgt[EW-1:0];
    assign nx     = r_next[t];
    assign pv     = r_prev[t];

    assign o_sts.func      = r_func;
    assign o_sts.q_ok      = q_ok;
    assign o_sts.e_ok      = e_ok;
    assign o_sts.e_tagged  = (r_tag[e] != TAG_NONE);
    assign o_sts.e_in_q    = (r_tag[e] == TW'(r_qid));
    assign o_sts.head_none = (hd >= LINK_NONE);
    assign o_sts.ins_stop  = !pos_ok || (r_steps >= SW'(ENTRIES)) || (r_pri > r_prio[p]);
    assign o_sts.clr_stop  = !pos_ok || (r_steps >= SW'(ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUES; i++) begin
                r_head[i] <= LINK_NONE;
                r_tail[i] <= LINK_NONE;
            end
            for (int i = 0; i < ENTRIES; i++) r_tag[i] <= TAG_NONE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.respond;
            if (i_cmd.latch) begin
                r_func   <= i_func;
                r_qid    <= i_queue_id;
                r_ent    <= i_entry;
                r_pri    <= i_priority_req[PRIO_BITS-1:0];
                r_status <= ST_OK;
                r_oe     <= '0;
            end
            if (i_cmd.decode) begin
                r_pos   <= hd;
                r_steps <= '0;
            end
            if (i_cmd.decode && !i_cmd.unlink) begin
                // decode cycle without unlink: set failure status or capture the peeked head
                if (!q_ok) r_status <= ST_NONE;
                else begin
                    case (r_func)
                        F_INSERT: begin
                            if (!e_ok) r_status <= ST_NONE;
                            else if (o_sts.e_tagged) r_status <= ST_DUPL;
                        end
                        F_REM_HEAD, F_PEEK: begin
                            if (o_sts.head_none) r_status <= ST_NONE;
                            else r_oe <= 5'(hd[EW-1:0]);
                        end
                        F_REM_ENT: r_status <= ST_NONE;
                        default: ;
                    endcase
                end
            end
            if (i_cmd.walk_ins) begin
                r_pos   <= r_next[p];
                r_steps <= r_steps + 1'b1;
            end
            if (i_cmd.walk_clr) begin
                r_tag[p] <= TAG_NONE;
                r_pos    <= r_next[p];
                r_steps  <= r_steps + 1'b1;
            end
            if (i_cmd.clr_done) begin
                r_head[q] <= LINK_NONE;
                r_tail[q] <= LINK_NONE;
            end
            if (i_cmd.unlink) begin
                r_oe <= 5'(t);
                if (pv < LINK_NONE) r_next[pv[EW-1:0]] <= nx;
                else                r_head[q] <= nx;
                if (nx < LINK_NONE) r_prev[nx[EW-1:0]] <= pv;
                else                r_tail[q] <= pv;
                r_tag[t] <= TAG_NONE;
            end
            if (i_cmd.ins_wb) begin
                r_prio[e] <= r_pri;
                r_tag[e]  <= TW'(r_qid);
                if (!pos_ok) begin
                    r_prev[e] <= r_tail[q];
                    r_next[e] <= LINK_NONE;
                    if (r_tail[q] < LINK_NONE) r_next[r_tail[q][EW-1:0]] <= LW'(r_ent);
                    else                       r_head[q] <= LW'(r_ent);
                    r_tail[q] <= LW'(r_ent);
                end else begin
                    r_prev[e] <= r_prev[p];
                    r_next[e] <= r_pos;
                    r_prev[p] <= LW'(r_ent);
                    if (r_prev[p] < LINK_NONE) r_next[r_prev[p][EW-1:0]] <= LW'(r_ent);
                    else                       r_head[q] <= LW'(r_ent);
                end
            end
        end
    end

    assign o_status    = r_status;
    assign o_out_entry = (r_status == ST_OK) ? r_oe : 5'd0;
    assign o_is_empty  = !q_ok || (hd >= LINK_NONE);

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk_ins || i_cmd.walk_clr) |-> (r_steps < SW'(ENTRIES)))
        else $error("walk overran");
    a_dup_noins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wb |-> (r_tag[e] == TAG_NONE)) else $error("insert of queued entry");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 2'd3)) else $error("bad status");

endmodule

@@ src/priority_process_queue_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_process_queue_bank
// Bank of priority-ordered linked queues sharing one entry pool.
// ----------------------------------------------------------------------------
// Steps: every op latches, decodes and ends with a respond step; insert walks
// at most ENTRIES entries, then stops and writes back; make-empty walks the
// queue entry by entry (at most ENTRIES), then clears head and tail.
// Throughput: one word at a time; busy drops in the cycle of the result strobe.
// Result strobe o_valid lasts one cycle; the receiver cannot stall.
// Reset: synchronous, active low; all queues empty and all entries untagged.
module priority_process_queue_bank
    import ppqb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_func,
    input  logic [2:0] i_queue_id,
    input  logic [4:0] i_entry,
    input  logic [7:0] i_priority_req,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [4:0] o_out_entry,
    output logic       o_is_empty
);

    t_cmd cmd;
    t_sts sts;

    ppqb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    ppqb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_queue_id     (i_queue_id),
        .i_entry        (i_entry),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_entry    (o_out_entry),
        .o_is_empty     (o_is_empty)
    );

endmodule

@@ bench/ppqb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppqb_checker
// Watches accepted commands and result words of the queue bank, keeps a
// shadow of every queue as an ordered list, and compares each result word
// with the predicted one.
// ----------------------------------------------------------------------------
module ppqb_checker
    import ppqb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [2:0] i_func,
    input  logic [2:0] i_queue_id,
    input  logic [4:0] i_entry,
    input  logic [7:0] i_priority_req,
    input  logic       o_valid,
    input  logic [1:0] o_status,
    input  logic [4:0] o_out_entry,
    input  logic       o_is_empty,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] out_entry;
        logic       is_empty;
    } t_answer;

    logic [4:0]     shadow_q[QUEUES][$];
    logic [7:0]     shadow_prio[ENTRIES];
    logic [TW-1:0]  shadow_tag[ENTRIES];
    t_answer        answers_due[$];

    function automatic t_answer apply_command(logic [2:0] fn, logic [2:0] q,
                                              logic [4:0] e, logic [7:0] p);
        t_answer a;
        int pos;
        a = '0;
        case (fn)
            F_INSERT: begin
                if (shadow_tag[e] != TAG_NONE) begin
                    a.status = ST_DUPL;
                end else begin
                    pos = 0;
                    while (pos < shadow_q[q].size() &&
                           p <= shadow_prio[shadow_q[q][pos]])
                        pos++;
                    shadow_q[q].insert(pos, e);
                    shadow_prio[e] = p;
                    shadow_tag[e] = TW'(q);
                end
            end
            F_REM_HEAD, F_PEEK: begin
                if (shadow_q[q].size() == 0) begin
                    a.status = ST_NONE;
                end else begin
                    a.out_entry = shadow_q[q][0];
                    if (fn == F_REM_HEAD) begin
                        shadow_tag[shadow_q[q][0]] = TAG_NONE;
                        void'(shadow_q[q].pop_front());
                    end
                end
            end
            F_REM_ENT: begin
                if (shadow_tag[e] != TW'(q)) begin
                    a.status = ST_NONE;
                end else begin
                    pos = 0;
                    for (int i = 0; i < shadow_q[q].size(); i++)
                        if (shadow_q[q][i] == e) pos = i;
                    shadow_q[q].delete(pos);
                    shadow_tag[e] = TAG_NONE;
                    a.out_entry = e;
                end
            end
            F_MAKE_EMP: begin
                for (int i = 0; i < shadow_q[q].size(); i++)
                    shadow_tag[shadow_q[q][i]] = TAG_NONE;
                shadow_q[q].delete();
            end
            default: ;
        endcase
        a.is_empty = (shadow_q[q].size() == 0);
        return a;
    endfunction

    assign o_pending = answers_due.size();

    always @(posedge i_clk) begin
        t_answer got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUES; i++) shadow_q[i].delete();
            for (int i = 0; i < ENTRIES; i++) shadow_tag[i] = TAG_NONE;
            answers_due.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (o_valid) begin
                got = {o_status, o_out_entry, o_is_empty};
                o_results <= o_results + 1;
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected word, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (got !== want) begin
                        $display({"%0t: mismatch, expected st=%0d ent=%0d emp=%0d,",
                                  " actual st=%0d ent=%0d emp=%0d"},
                                 $time, want.status, want.out_entry, want.is_empty,
                                 o_status, o_out_entry, o_is_empty);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (start && !busy)
                answers_due.push_back(apply_command(i_func, i_queue_id,
                                                    i_entry, i_priority_req));
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random queue commands into the queue bank in bursts
// and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench;
    import ppqb_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [2:0] i_func;
    logic [2:0] i_queue_id;
    logic [4:0] i_entry;
    logic [7:0] i_priority_req;
    logic       o_valid;
    logic [1:0] o_status;
    logic [4:0] o_out_entry;
    logic       o_is_empty;
    int         errors, pending, results;
    int         sent;

    priority_process_queue_bank dut (.*);

    ppqb_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_func, .i_queue_id, .i_entry,
        .i_priority_req, .o_valid, .o_status, .o_out_entry, .o_is_empty,
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // hold one word until accepted; start drops only when the caller says so
    task automatic send_word(logic [2:0] fn, logic [2:0] q, logic [4:0] e,
                             logic [7:0] p);
        start <= 1'b1;
        i_func <= fn;
        i_queue_id <= q;
        i_entry <= e;
        i_priority_req <= p;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic idle_gap(int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [2:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return F_INSERT;
        if (r < 55) return F_REM_HEAD;
        if (r < 65) return F_PEEK;
        if (r < 82) return F_REM_ENT;
        if (r < 88) return F_EMPTY_T;
        if (r < 94) return F_MAKE_EMP;
        return 3'($urandom_range(6, 7));
    endfunction

    initial begin
        int burst;
        logic [2:0] q;
        start = 1'b0;
        i_func = '0;
        i_queue_id = '0;
        i_entry = '0;
        i_priority_req = '0;
        i_rst_n = 1'b0;
        sent = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(F_REM_HEAD, 0, 0, 0);
        send_word(F_PEEK, 7, 0, 0);
        send_word(F_INSERT, 0, 0, 8'h00);
        send_word(F_INSERT, 0, 31, 8'hff);
        send_word(F_INSERT, 0, 5, 8'h80);
        send_word(F_INSERT, 0, 6, 8'h80);
        send_word(F_INSERT, 0, 7, 8'hff);
        send_word(F_INSERT, 7, 5, 8'h10);
        send_word(F_PEEK, 0, 0, 0);
        send_word(F_REM_ENT, 7, 5, 0);
        send_word(F_REM_ENT, 0, 6, 0);
        send_word(F_REM_ENT, 0, 6, 0);
        send_word(F_REM_HEAD, 0, 0, 0);
        send_word(F_EMPTY_T, 0, 0, 0);
        send_word(3'd6, 0, 0, 0);
        send_word(3'd7, 7, 31, 8'hff);
        send_word(F_MAKE_EMP, 0, 0, 0);
        send_word(F_EMPTY_T, 0, 0, 0);
        send_word(F_INSERT, 3, 31, 8'h55);
        send_word(F_MAKE_EMP, 5, 0, 0);
        send_word(F_REM_ENT, 3, 31, 0);
        idle_gap(1);
        wait (pending == 0);
        @(negedge i_clk);

        while (sent < 550) begin
            burst = $urandom_range(1, 12);
            q = 3'($urandom_range(0, 7));
            repeat (burst) begin
                if ($urandom_range(0, 3) == 0) q = 3'($urandom_range(0, 7));
                send_word(pick_func(), q, 5'($urandom), 8'($urandom));
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
            if (sent > 300 && sent < 315) begin
                idle_gap(1);
                wait (pending == 0);
                @(negedge i_clk);
            end
        end
        idle_gap(1);
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        $display("covered %0d commands, %0d result words, all functions on all queues",
                 sent, results);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
